// ----- rtl/f64dac_pkg.sv -----
package f64dac_pkg;

  localparam int TAPS_DEF         = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 16;

  localparam int ACC_WIDTH   = 64;
  localparam int CODE_WIDTH  = 10;
  localparam int CODE_MAX    = 1023;
  localparam int DAC_GAIN    = 200;
  localparam int DAC_OFFSET  = 500;
  localparam int TABLE_LEN   = 64;
  localparam int TABLE_IDX_W = 6;

  // register byte addresses (one register, word index in paddr[2])
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_FILTER_MODE = 1'b0;

  localparam logic [1:0] MODE_BANK_A = 2'd2;
  localparam logic [1:0] MODE_BANK_B = 2'd3;

  // coefficients in millionths
  localparam int BANK_A_MICRO [TABLE_LEN] = '{
    -757, -497, 0, 644, 1245, 1507, 1134, 0,
    -1675, -3269, -3917, -2882, 0, 4006, 7579, 8820,
    6320, 0, -8423, -15697, -18079, -12884, 0, 17307,
    32770, 38763, 28789, 0, -45174, -98993, -150151, -186837,
    800659, -186837, -150151, -98993, -45174, 0, 28789, 38763,
    32770, 17307, 0, -12884, -18079, -15697, -8423, 0,
    6320, 8820, 7579, 4006, 0, -2882, -3917, -3269,
    -1675, 0, 1134, 1507, 1245, 644, 0, -497
  };

  localparam int BANK_B_MICRO [TABLE_LEN] = '{
    2044, 7806, 14554, 20018, 24374, 27780, 30370, 32264,
    33568, 34372, 34757, 34791, 34534, 34040, 33353, 32511,
    31549, 30496, 29375, 28207, 27010, 25800, 24587, 23383,
    22195, 21031, 19896, 18795, 17730, 16703, 15718, 14774,
    13872, 13013, 12196, 11420, 10684, 9989, 9331, 8711,
    8127, 7577, 7061, 6575, 6120, 5693, 5294, 4920,
    4570, 4244, 3939, 3655, 3389, 3142, 2912, 2698,
    2499, 2313, 2141, 1981, 1833, 1695, 1567, 1448
  };

  // scale a value in millionths to Q1.(cw-1), round half away from zero
  function automatic longint coef_q(input int micro, input int cw);
    longint num;
    num = longint'(micro) * (longint'(1) <<< (cw - 1));
    if (micro < 0) begin
      num = num - 64'sd500000;
    end else begin
      num = num + 64'sd500000;
    end
    return num / 64'sd1000000;
  endfunction

endpackage

// ----- rtl/f64dac_ram.sv -----
module f64dac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/f64dac_coef_rom.sv -----
module f64dac_coef_rom #(
  parameter int TAPS       = f64dac_pkg::TAPS_DEF,
  parameter int COEF_WIDTH = f64dac_pkg::COEF_WIDTH_DEF
) (
  input  logic                          bank_sel,
  input  logic [$clog2(TAPS)-1:0]       tap_idx,
  output logic signed [COEF_WIDTH-1:0]  coef
);

  localparam int KW = $clog2(TAPS);
  // wide enough to hold the table length itself for the range compare
  localparam int IW = (KW > f64dac_pkg::TABLE_IDX_W) ? KW : f64dac_pkg::TABLE_IDX_W + 1;

  logic signed [COEF_WIDTH-1:0] rom_a [f64dac_pkg::TABLE_LEN];
  logic signed [COEF_WIDTH-1:0] rom_b [f64dac_pkg::TABLE_LEN];
  logic [IW-1:0]                idx_x;

  for (genvar g = 0; g < f64dac_pkg::TABLE_LEN; g++) begin : g_rom
    assign rom_a[g] = COEF_WIDTH'(f64dac_pkg::coef_q(f64dac_pkg::BANK_A_MICRO[g], COEF_WIDTH));
    assign rom_b[g] = COEF_WIDTH'(f64dac_pkg::coef_q(f64dac_pkg::BANK_B_MICRO[g], COEF_WIDTH));
  end

  assign idx_x = IW'(tap_idx);

  // taps past the end of the tables weigh zero
  always_comb begin
    if (idx_x < IW'(f64dac_pkg::TABLE_LEN)) begin
      if (bank_sel) begin
        coef = rom_b[idx_x[f64dac_pkg::TABLE_IDX_W-1:0]];
      end else begin
        coef = rom_a[idx_x[f64dac_pkg::TABLE_IDX_W-1:0]];
      end
    end else begin
      coef = '0;
    end
  end

endmodule

// ----- rtl/fir64_two_bank_dac_scaler_unit.sv -----
// FIR filter with two fixed coefficient banks and a 10-bit converter code.
// One signed Q3.12 word enters per item; in filter mode (2 = first bank,
// 3 = second bank) a single multiply-accumulate unit walks all TAPS taps, one
// per cycle, reading the delay line from a one-read-port RAM; the item then
// passes the drain, round, scale and output states. In bypass mode (0, 1)
// it goes straight to the scale and output states. The input side is ready
// only between items; a finished word waits in the output register without
// stalling the next accept. in_tuser set clears the delay line before the
// word is used, also in bypass. out_tdata carries the saturated sample and
// floor((y + 2.5) * 200) clamped to 0..1023. No clearing pass after reset.
module fir64_two_bank_dac_scaler_unit #(
  parameter int TAPS         = f64dac_pkg::TAPS_DEF,
  parameter int SAMPLE_WIDTH = f64dac_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = f64dac_pkg::COEF_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] in_tdata,  // sample_in
  input  logic                                    in_tuser,  // restart
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // sample_out, dac_code
  output logic [((SAMPLE_WIDTH + f64dac_pkg::CODE_WIDTH + 7) / 8) * 8-1:0] out_tdata,
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [f64dac_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                             cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int DEPTH = TAPS - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(TAPS);
  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COEF_WIDTH;
  localparam int PW    = SW + CW;
  localparam int ACCW  = f64dac_pkg::ACC_WIDTH;
  localparam int CODEW = f64dac_pkg::CODE_WIDTH;
  localparam int OUT_W = ((SW + CODEW + 7) / 8) * 8;
  localparam int FRAC  = SW - 4;
  localparam int DW    = SW + 10;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [KW-1:0] LAST_TAP  = KW'(TAPS - 1);

  localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(longint'(1) <<< (CW - 2));
  localparam logic signed [ACCW-1:0] Y_HI     = ACCW'((longint'(1) <<< (SW - 1)) - 1);
  localparam logic signed [ACCW-1:0] Y_LO     = -Y_HI - ACCW'(1);
  localparam logic signed [DW-1:0]   DAC_OFS  =
    DW'(longint'(f64dac_pkg::DAC_OFFSET) <<< FRAC);
  localparam logic signed [DW-1:0]   CODE_TOP = DW'(f64dac_pkg::CODE_MAX);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_DAC   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [1:0]              mode_r;
  logic [AW-1:0]           wp_r;
  logic [AW-1:0]           rp_r;
  logic [KW-1:0]           k_r;
  logic [DEPTH-1:0]        ent_vld_r;
  logic signed [SW-1:0]    x_r;
  logic                    bank_r;
  logic                    s1_vld_r;
  logic signed [CW-1:0]    s1_coef_r;
  logic                    s1_use_x_r;
  logic                    s1_ent_r;
  logic                    s2_vld_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACCW-1:0]  acc_r;
  logic signed [SW-1:0]    y_r;
  logic [CODEW-1:0]        code_r;
  logic                    out_vld_r;
  logic [SW-1:0]           out_sample_r;
  logic [CODEW-1:0]        out_code_r;

  logic                    in_acc;
  logic                    cfg_wr;
  logic                    filt_mode;
  logic                    issue;
  logic                    ram_we;
  logic [SW-1:0]           ram_q;
  logic signed [CW-1:0]    coef;
  logic signed [SW-1:0]    operand;
  logic signed [ACCW-1:0]  rnd;
  logic signed [ACCW-1:0]  sh;
  logic signed [SW-1:0]    y_sat;
  logic signed [DW-1:0]    y_ext;
  logic signed [DW-1:0]    dac_t;
  logic signed [DW-1:0]    dac_q;
  logic [CODEW-1:0]        code_nxt;
  logic                    out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign filt_mode  = (mode_r == f64dac_pkg::MODE_BANK_A) ||
                      (mode_r == f64dac_pkg::MODE_BANK_B);
  assign issue      = (state_r == S_MAC);
  assign ram_we     = (state_r == S_ROUND);
  assign out_free   = !out_vld_r || out_tready;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == f64dac_pkg::REG_FILTER_MODE);
  assign cfg_prdata = (cfg_paddr[2] == f64dac_pkg::REG_FILTER_MODE) ? 32'(mode_r) : 32'd0;

  f64dac_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (rp_r),
    .rdata (ram_q)
  );

  f64dac_coef_rom #(
    .TAPS       (TAPS),
    .COEF_WIDTH (CW)
  ) u_coef_rom (
    .bank_sel (bank_r),
    .tap_idx  (k_r),
    .coef     (coef)
  );

  // tap zero multiplies the incoming word; entries not written since restart read zero
  assign operand = s1_use_x_r ? x_r : (s1_ent_r ? $signed(ram_q) : '0);

  // round to Q3.12 and saturate
  assign rnd = acc_r + RND_HALF;
  assign sh  = rnd >>> (CW - 1);
  always_comb begin
    if (sh > Y_HI) begin
      y_sat = SW'(Y_HI);
    end else if (sh < Y_LO) begin
      y_sat = SW'(Y_LO);
    end else begin
      y_sat = SW'(sh);
    end
  end

  // converter code: y*200 as shift-add, offset 500 (2.5 times 200) in Q.FRAC
  assign y_ext = DW'(y_r);
  assign dac_t = (y_ext <<< 7) + (y_ext <<< 6) + (y_ext <<< 3) + DAC_OFS;
  assign dac_q = dac_t >>> FRAC;
  always_comb begin
    if (dac_t < 0) begin
      code_nxt = '0;
    end else if (dac_q > CODE_TOP) begin
      code_nxt = CODEW'(f64dac_pkg::CODE_MAX);
    end else begin
      code_nxt = CODEW'(dac_q);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = filt_mode ? S_MAC : S_DAC;
        end
      end
      S_MAC: begin
        if (k_r == LAST_TAP) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_DAC;
      S_DAC:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= '0;
      wp_r      <= '0;
      ent_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (cfg_wr) begin
        mode_r <= cfg_pwdata[1:0];
      end
      if (in_acc && in_tuser) begin
        ent_vld_r <= '0;
      end
      if (ram_we) begin
        ent_vld_r[wp_r] <= 1'b1;
        wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= $signed(in_tdata[SW-1:0]);
      y_r    <= $signed(in_tdata[SW-1:0]);
      bank_r <= (mode_r == f64dac_pkg::MODE_BANK_B);
      k_r    <= '0;
      rp_r   <= (wp_r == '0) ? LAST_ADDR : wp_r - AW'(1);
      acc_r  <= '0;
    end
    if (issue) begin
      s1_coef_r  <= coef;
      s1_use_x_r <= (k_r == '0);
      s1_ent_r   <= ent_vld_r[rp_r];
      if (k_r != LAST_TAP) begin
        k_r <= k_r + KW'(1);
      end
      // walk back toward the oldest entry once the incoming word is issued
      if (k_r != '0) begin
        rp_r <= (rp_r == '0) ? LAST_ADDR : rp_r - AW'(1);
      end
    end
    if (s1_vld_r) begin
      prod_r <= s1_coef_r * operand;
    end
    if (s2_vld_r) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end
    if (state_r == S_ROUND) begin
      y_r <= y_sat;
    end
    if (state_r == S_DAC) begin
      code_r <= code_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      out_sample_r <= y_r;
      out_code_r   <= code_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({out_code_r, out_sample_r});

endmodule

// ----- tb/fir64_two_bank_dac_scaler_unit_tb.sv -----
module fir64_two_bank_dac_scaler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS    = f64dac_pkg::TAPS_DEF;
  localparam int SW       = f64dac_pkg::SAMPLE_WIDTH_DEF;
  localparam int CW       = f64dac_pkg::COEF_WIDTH_DEF;
  localparam int FRAC     = SW - 4;
  localparam int CODE_W   = f64dac_pkg::CODE_WIDTH;
  localparam int OUT_W    = ((SW + CODE_W + 7) / 8) * 8;
  localparam int RUN_WORDS = 1900;
  localparam int LIMIT    = 1000000;

  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_PASS_ALT = 2'd1;
  localparam logic [1:0] MODE_BANK_A   = f64dac_pkg::MODE_BANK_A;
  localparam logic [1:0] MODE_BANK_B   = f64dac_pkg::MODE_BANK_B;

  localparam logic [f64dac_pkg::CFG_ADDR_W-1:0] ADDR_FILTER_MODE = 3'd0;
  localparam logic [f64dac_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;

  localparam logic signed [SW-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SW-1:0] S_MIN = 16'sh8000;

  // tap weights in millionths
  localparam int TAPS_A_PPM [64] = '{
    -757, -497, 0, 644, 1245, 1507, 1134, 0,
    -1675, -3269, -3917, -2882, 0, 4006, 7579, 8820,
    6320, 0, -8423, -15697, -18079, -12884, 0, 17307,
    32770, 38763, 28789, 0, -45174, -98993, -150151, -186837,
    800659, -186837, -150151, -98993, -45174, 0, 28789, 38763,
    32770, 17307, 0, -12884, -18079, -15697, -8423, 0,
    6320, 8820, 7579, 4006, 0, -2882, -3917, -3269,
    -1675, 0, 1134, 1507, 1245, 644, 0, -497
  };
  localparam int TAPS_B_PPM [64] = '{
    2044, 7806, 14554, 20018, 24374, 27780, 30370, 32264,
    33568, 34372, 34757, 34791, 34534, 34040, 33353, 32511,
    31549, 30496, 29375, 28207, 27010, 25800, 24587, 23383,
    22195, 21031, 19896, 18795, 17730, 16703, 15718, 14774,
    13872, 13013, 12196, 11420, 10684, 9989, 9331, 8711,
    8127, 7577, 7061, 6575, 6120, 5693, 5294, 4920,
    4570, 4244, 3939, 3655, 3389, 3142, 2912, 2698,
    2499, 2313, 2141, 1981, 1833, 1695, 1567, 1448
  };

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 restart;
  } in_word_t;

  typedef struct packed {
    logic [SW-1:0]     sample;
    logic [CODE_W-1:0] code;
  } out_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SW-1:0]       in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [f64dac_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  fir64_two_bank_dac_scaler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // sample_in
    .in_tuser   (in_tuser),   // restart
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // sample_out, dac_code
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  in_word_t             pending_words [$];
  out_word_t            filtered_due [$];
  longint               weight_a [64];
  longint               weight_b [64];
  logic signed [SW-1:0] tap_hist [NTAPS-1];
  logic [1:0]           filt_mode = MODE_PASS;
  bit                   idle_on = 1'b1;
  int                   in_wait = 0;
  int                   out_wait = 0;
  int                   words_queued = 0;
  int                   words_checked = 0;
  int                   errors = 0;
  int                   cycle = 0;

  function automatic longint to_q15(input int ppm);
    longint num;
    num = longint'(ppm) * (longint'(1) <<< (CW - 1));
    num = num + ((ppm < 0) ? -64'sd500000 : 64'sd500000);
    return num / 64'sd1000000;
  endfunction

  // expected word for one accepted sample; advances the tap history in filter mode
  function automatic out_word_t filter_sample(input logic signed [SW-1:0] x,
                                              input logic clr);
    longint    acc;
    longint    y;
    longint    t;
    longint    w;
    int        k;
    out_word_t r;
    if (clr) begin
      for (k = 0; k < NTAPS - 1; k++) tap_hist[k] = '0;
    end
    if (filt_mode == MODE_BANK_A || filt_mode == MODE_BANK_B) begin
      acc = 0;
      for (k = 0; k < NTAPS; k++) begin
        w = (k >= 64) ? 0 : ((filt_mode == MODE_BANK_B) ? weight_b[k] : weight_a[k]);
        acc += w * ((k == 0) ? longint'(x) : longint'(tap_hist[k-1]));
      end
      acc += longint'(1) <<< (CW - 2);
      y = acc >>> (CW - 1);
      if (y > longint'(S_MAX)) y = longint'(S_MAX);
      if (y < longint'(S_MIN)) y = longint'(S_MIN);
      for (k = NTAPS - 2; k > 0; k--) tap_hist[k] = tap_hist[k-1];
      tap_hist[0] = x;
    end else begin
      y = longint'(x);
    end
    t = y * f64dac_pkg::DAC_GAIN + (longint'(f64dac_pkg::DAC_OFFSET) <<< FRAC);
    if (t < 0) begin
      t = 0;
    end else begin
      t = t >>> FRAC;
      if (t > f64dac_pkg::CODE_MAX) t = f64dac_pkg::CODE_MAX;
    end
    r.sample = y[SW-1:0];
    r.code   = t[CODE_W-1:0];
    return r;
  endfunction

  function automatic void queue_word(input logic signed [SW-1:0] s, input logic clr);
    in_word_t w;
    w.sample = s;
    w.restart = clr;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  // input driver; predicts at each accepted word
  always @(posedge clk) begin
    in_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        filtered_due.push_back(filter_sample($signed(in_tdata), in_tuser));
        in_wait = draw_wait();
      end
      if (in_wait > 0 || pending_words.size() == 0) begin
        in_tvalid <= 1'b0;
        if (in_wait > 0) in_wait--;
      end else begin
        w = pending_words.pop_front();
        in_tdata  <= w.sample;
        in_tuser  <= w.restart;
        in_tvalid <= 1'b1;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (filtered_due.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h", $time, out_tdata);
          errors++;
        end else begin
          e = filtered_due.pop_front();
          words_checked++;
          if (out_tdata[SW-1:0] !== e.sample) begin
            $display("%0t: sample_out expected %0d got %0d", $time,
                     $signed(e.sample), $signed(out_tdata[SW-1:0]));
            errors++;
          end
          if (out_tdata[SW+CODE_W-1:SW] !== e.code) begin
            $display("%0t: dac_code expected %0d got %0d", $time,
                     e.code, out_tdata[SW+CODE_W-1:SW]);
            errors++;
          end
        end
        out_wait = draw_wait();
      end
      if (out_wait > 0) begin
        out_tready <= 1'b0;
        out_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("fir64_two_bank_dac_scaler_unit_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [f64dac_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_FILTER_MODE) filt_mode = data[1:0];
  endtask

  task automatic set_mode(input logic [1:0] m);
    logic [31:0] d;
    d = $urandom();
    d[1:0] = m;
    write_reg(ADDR_FILTER_MODE, d);
  endtask

  // hold until every queued word has come back
  task automatic wait_drained();
    while (words_checked != words_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int   j;
    int   len;
    int   n;
    int   pol;
    int   ppm;
    logic signed [SW-1:0] s;
    for (j = 0; j < 64; j++) begin
      weight_a[j] = to_q15(TAPS_A_PPM[j]);
      weight_b[j] = to_q15(TAPS_B_PPM[j]);
    end
    for (j = 0; j < NTAPS - 1; j++) tap_hist[j] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // bypass after reset: code clamps at both ends and the -2.5 boundary
    queue_word(S_MAX, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(16'sd0, 1'b0);
    queue_word(-16'sd10240, 1'b0);
    queue_word(16'sd10711, 1'b0);
    wait_drained();

    set_mode(MODE_BANK_A);
    queue_word(S_MAX, 1'b1);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MAX, 1'b0);
    queue_word(16'sd0, 1'b0);
    queue_word(16'sd1, 1'b0);
    queue_word(-16'sd1, 1'b0);
    wait_drained();

    // write off the map must leave the mode alone
    write_reg(ADDR_UNMAPPED, 32'hffff_fffc);
    queue_word(S_MIN, 1'b0);
    queue_word(16'sd4096, 1'b0);
    wait_drained();

    // restart in bypass still clears the history
    set_mode(MODE_PASS);
    queue_word(16'sd4096, 1'b1);
    wait_drained();
    set_mode(MODE_BANK_A);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MAX, 1'b0);
    queue_word(16'sd2048, 1'b0);
    wait_drained();

    set_mode(MODE_PASS_ALT);
    queue_word(-16'sd20000, 1'b0);
    queue_word(16'sd20000, 1'b1);
    wait_drained();

    set_mode(MODE_BANK_B);
    queue_word(S_MAX, 1'b1);
    queue_word(S_MAX, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(16'sd0, 1'b0);
    wait_drained();

    while (words_queued < RUN_WORDS) begin
      set_mode(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0) write_reg(ADDR_UNMAPPED, $urandom());
      idle_on = ($urandom_range(0, 4) != 0);
      len = $urandom_range(20, 120);
      n = 0;
      while (n < len) begin
        case ($urandom_range(0, 11))
          0: begin
            // drive every tap to its extreme with the sign of its weight
            pol = $urandom_range(0, 1) ? 1 : -1;
            for (j = 0; j < 64; j++) begin
              ppm = (filt_mode == MODE_BANK_B) ? 1 : TAPS_A_PPM[63-j];
              if (ppm == 0) s = SW'($urandom());
              else s = (ppm * pol > 0) ? S_MAX : S_MIN;
              queue_word(s, 1'b0);
            end
            n += 64;
          end
          1, 2: begin
            case ($urandom_range(0, 4))
              0: s = S_MAX;
              1: s = S_MIN;
              2: s = 16'sd0;
              3: s = 16'sd1;
              default: s = -16'sd1;
            endcase
            queue_word(s, ($urandom_range(0, 15) == 0));
            n++;
          end
          3, 4, 5: begin
            s = SW'($urandom_range(0, 8191) - 4096);
            queue_word(s, ($urandom_range(0, 31) == 0));
            n++;
          end
          default: begin
            s = SW'($urandom());
            queue_word(s, ($urandom_range(0, 31) == 0));
            n++;
          end
        endcase
      end
      wait_drained();
    end

    repeat (NTAPS + 16) @(posedge clk);
    if (errors == 0 && filtered_due.size() == 0) begin
      $display("fir64_two_bank_dac_scaler_unit_tb: clean");
    end else begin
      if (filtered_due.size() != 0)
        $display("%0t: %0d words still expected, got none", $time, filtered_due.size());
      $display("fir64_two_bank_dac_scaler_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/f64dac_pkg.sv
rtl/f64dac_ram.sv
rtl/f64dac_coef_rom.sv
rtl/fir64_two_bank_dac_scaler_unit.sv
tb/fir64_two_bank_dac_scaler_unit_tb.sv
